// ===== rtl/core/rfeu_pkg.sv =====
// ----------------------------------------------------------------------------
// rfeu_pkg - register file execute unit package
// Shared codes, widths and types for the execute unit and its channels.
// ----------------------------------------------------------------------------
package rfeu_pkg;

  localparam int FUNC_W  = 2;
  localparam int REG_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;

  localparam int NUM_BYTE_REGS = 4;
  localparam int NUM_WORD_REGS = 6;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_SET = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUM = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_JNZ = 2'd3;

  // Register codes.
  localparam logic [REG_W-1:0] REG_WORD0 = 4'd4;
  localparam logic [REG_W-1:0] REG_SI    = 4'd8;
  localparam logic [REG_W-1:0] REG_DI    = 4'd9;
  localparam logic [REG_W-1:0] REG_PC    = 4'd10;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [REG_W-1:0]  dest_reg;
    logic [REG_W-1:0]  src_reg;
    logic [WORD_W-1:0] immediate;
  } instr_t;

  // Write requests from the execute logic to the register file.
  typedef struct packed {
    logic              reg_wr_en;
    logic [REG_W-1:0]  reg_wr_code;
    logic [WORD_W-1:0] reg_wr_data;
    logic              pc_wr_en;
    logic [WORD_W-1:0] pc_wr_data;
  } wr_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] pc_value;
    logic              pc_modified;
    logic [WORD_W-1:0] dest_value;
  } result_t;

endpackage

// ===== rtl/core/rfeu_channels.sv =====
// ----------------------------------------------------------------------------
// rfeu_channels - valid/ready channels of the execute unit
// Instruction channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface rfeu_in_if
  import rfeu_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [REG_W-1:0]  dest_reg;
  logic [REG_W-1:0]  src_reg;
  logic [WORD_W-1:0] immediate;

  modport source (output valid, func, dest_reg, src_reg, immediate, input ready);
  modport sink   (input valid, func, dest_reg, src_reg, immediate, output ready);
endinterface

interface rfeu_out_if
  import rfeu_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] pc_value;
  logic              pc_modified;
  logic [WORD_W-1:0] dest_value;

  modport source (output valid, pc_value, pc_modified, dest_value, input ready);
  modport sink   (input valid, pc_value, pc_modified, dest_value, output ready);
endinterface

// ===== rtl/core/rfeu_regfile.sv =====
// ----------------------------------------------------------------------------
// rfeu_regfile - mixed-width register file
// Four byte registers, six word registers (SI, DI last) and the PC, with two
// zero-extended read ports and one write port plus a PC write port.
// ----------------------------------------------------------------------------
module rfeu_regfile
  import rfeu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_fire,
  input  wr_req_t           wr_req,
  input  logic [REG_W-1:0]  rd_a_code,
  input  logic [REG_W-1:0]  rd_b_code,
  output logic [WORD_W-1:0] rd_a_data,
  output logic [WORD_W-1:0] rd_b_data,
  output logic [WORD_W-1:0] pc
);

  logic [BYTE_W-1:0] byte_regs_r [NUM_BYTE_REGS];
  logic [WORD_W-1:0] word_regs_r [NUM_WORD_REGS];
  logic [WORD_W-1:0] pc_r;

  function automatic logic [WORD_W-1:0] read_reg(
    input logic [REG_W-1:0]  code,
    input logic [BYTE_W-1:0] bregs [NUM_BYTE_REGS],
    input logic [WORD_W-1:0] wregs [NUM_WORD_REGS],
    input logic [WORD_W-1:0] pcv
  );
    logic [REG_W-1:0] widx;
    widx = code - REG_WORD0;
    if (code < REG_WORD0) begin
      read_reg = {{(WORD_W-BYTE_W){1'b0}}, bregs[code[1:0]]};
    end else if (code < REG_PC) begin
      read_reg = wregs[widx[2:0]];
    end else if (code == REG_PC) begin
      read_reg = pcv;
    end else begin
      read_reg = '0;
    end
  endfunction

  assign rd_a_data = read_reg(rd_a_code, byte_regs_r, word_regs_r, pc_r);
  assign rd_b_data = read_reg(rd_b_code, byte_regs_r, word_regs_r, pc_r);
  assign pc        = pc_r;

  logic [REG_W-1:0] wr_widx;
  assign wr_widx = wr_req.reg_wr_code - REG_WORD0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BYTE_REGS; i++) byte_regs_r[i] <= '0;
      for (int i = 0; i < NUM_WORD_REGS; i++) word_regs_r[i] <= '0;
      pc_r <= '0;
    end else if (wr_fire) begin
      if (wr_req.reg_wr_en) begin
        if (wr_req.reg_wr_code < REG_WORD0) begin
          byte_regs_r[wr_req.reg_wr_code[1:0]] <= wr_req.reg_wr_data[BYTE_W-1:0];
        end else if (wr_req.reg_wr_code < REG_PC) begin
          word_regs_r[wr_widx[2:0]] <= wr_req.reg_wr_data;
        end else if (wr_req.reg_wr_code == REG_PC) begin
          pc_r <= wr_req.reg_wr_data;
        end
      end else if (wr_req.pc_wr_en) begin
        pc_r <= wr_req.pc_wr_data;
      end
    end
  end

endmodule

// ===== rtl/core/rfeu_exec.sv =====
// ----------------------------------------------------------------------------
// rfeu_exec - instruction execute logic
// Computes the register file writes and the result fields of one
// instruction from the operand values read this cycle.
// ----------------------------------------------------------------------------
module rfeu_exec
  import rfeu_pkg::*;
(
  input  instr_t            instr,
  input  logic [WORD_W-1:0] dest_val,
  input  logic [WORD_W-1:0] src_val,
  input  logic [WORD_W-1:0] pc,
  output wr_req_t           wr_req,
  output result_t           result
);

  logic              dst_byte;
  logic              dst_pc;
  logic              dst_used;
  logic [WORD_W-1:0] alu_res;
  logic [WORD_W-1:0] jnz_target;

  assign dst_byte = (instr.dest_reg < REG_WORD0);
  assign dst_pc   = (instr.dest_reg == REG_PC);
  assign dst_used = (instr.dest_reg <= REG_PC);

  assign jnz_target = (dest_val != '0) ? instr.immediate : pc + 32'd1;

  always_comb begin
    case (instr.func)
      FUNC_SET: alu_res = instr.immediate;
      FUNC_SUM: alu_res = dest_val + src_val;
      FUNC_SUB: alu_res = dest_val - src_val;
      default:  alu_res = jnz_target;
    endcase
  end

  always_comb begin
    wr_req.reg_wr_code = instr.dest_reg;
    wr_req.reg_wr_data = alu_res;
    wr_req.pc_wr_data  = jnz_target;
    result.pc_modified = 1'b0;
    if (instr.func == FUNC_JNZ) begin
      wr_req.reg_wr_en   = 1'b0;
      wr_req.pc_wr_en    = 1'b1;
      result.pc_modified = 1'b1;
      result.pc_value    = jnz_target;
      result.dest_value  = dst_pc ? jnz_target : dest_val;
    end else begin
      wr_req.reg_wr_en   = 1'b1;
      wr_req.pc_wr_en    = 1'b0;
      // Outside JNZ, only SET reports a PC write; SUM and SUB into PC change it silently.
      result.pc_modified = dst_pc && (instr.func == FUNC_SET);
      result.pc_value    = dst_pc ? alu_res : pc;
      if (!dst_used) begin
        result.dest_value = '0;
      end else if (dst_byte) begin
        result.dest_value = {{(WORD_W-BYTE_W){1'b0}}, alu_res[BYTE_W-1:0]};
      end else begin
        result.dest_value = alu_res;
      end
    end
  end

endmodule

// ===== rtl/core/register_file_execute_unit.sv =====
// Each instruction passes the input register and then the result register.
// Throughput: one instruction per cycle while results are accepted, dependent
// ones back to back, since the register file is read, updated and written
// back in one execute stage. A stalled result holds the execute stage, and
// the input stalls only while an instruction also waits in the input register.
// Reset (synchronous, rst_n low) clears only the register file, PC and valid flags.
// ----------------------------------------------------------------------------
// register_file_execute_unit - top level
// Input register, execute stage over the register file, result register.
// ----------------------------------------------------------------------------
module register_file_execute_unit
  import rfeu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rfeu_in_if.sink    in_if,
  rfeu_out_if.source out_if
);

  logic    stg_valid_r;
  instr_t  stg_instr_r;
  logic    out_valid_r;
  result_t out_result_r;

  logic              exec_fire;
  logic              in_fire;
  logic [WORD_W-1:0] dest_val;
  logic [WORD_W-1:0] src_val;
  logic [WORD_W-1:0] pc;
  wr_req_t           wr_req;
  result_t           result;

  assign exec_fire   = stg_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !stg_valid_r || exec_fire;
  assign in_fire     = in_if.valid && in_if.ready;

  rfeu_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_fire   (exec_fire),
    .wr_req    (wr_req),
    .rd_a_code (stg_instr_r.dest_reg),
    .rd_b_code (stg_instr_r.src_reg),
    .rd_a_data (dest_val),
    .rd_b_data (src_val),
    .pc        (pc)
  );

  rfeu_exec u_exec (
    .instr    (stg_instr_r),
    .dest_val (dest_val),
    .src_val  (src_val),
    .pc       (pc),
    .wr_req   (wr_req),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      stg_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_instr_r.func      <= in_if.func;
      stg_instr_r.dest_reg  <= in_if.dest_reg;
      stg_instr_r.src_reg   <= in_if.src_reg;
      stg_instr_r.immediate <= in_if.immediate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_result_r <= result;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.pc_value    = out_result_r.pc_value;
  assign out_if.pc_modified = out_result_r.pc_modified;
  assign out_if.dest_value  = out_result_r.dest_value;

`ifndef ASSERT_OFF
  // Every executed JNZ reports a PC write in its result.
  a_jnz_modified: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && (stg_instr_r.func == FUNC_JNZ) |=> out_result_r.pc_modified)
    else $error("JNZ result without pc_modified");

  // A SET into PC shows the immediate as the new PC.
  a_set_pc: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && (stg_instr_r.func == FUNC_SET) && (stg_instr_r.dest_reg == REG_PC)
    |=> (out_result_r.pc_value == $past(stg_instr_r.immediate)))
    else $error("SET to PC gave wrong pc_value");

  // An instruction held in the input register is not lost while stalled.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !exec_fire |=> stg_valid_r && $stable(stg_instr_r))
    else $error("stalled instruction dropped or changed");

  // The input side stalls only behind a blocked result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> stg_valid_r && out_valid_r && !out_if.ready)
    else $error("input stalled without cause");
`endif

endmodule

// ===== tb/sv/register_file_execute_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_file_execute_checker - result checker for the execute unit
// Watches both channels, runs its own copy of the register file on every
// accepted instruction and compares each result transaction, field by field,
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module register_file_execute_checker
  import rfeu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rfeu_in_if          in_ch,
  rfeu_out_if         out_ch,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);

  logic [BYTE_W-1:0] byte_file [NUM_BYTE_REGS];
  logic [WORD_W-1:0] word_file [NUM_WORD_REGS];
  logic [WORD_W-1:0] pc_reg;

  result_t expected_results [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [WORD_W-1:0] read_reg(input logic [REG_W-1:0] code);
    if (code < REG_WORD0) return WORD_W'(byte_file[code[1:0]]);
    if (code < REG_PC) return word_file[3'(code - REG_WORD0)];
    if (code == REG_PC) return pc_reg;
    return '0;
  endfunction

  function automatic void write_reg(input logic [REG_W-1:0] code,
                                    input logic [WORD_W-1:0] value);
    if (code < REG_WORD0) begin
      byte_file[code[1:0]] = value[BYTE_W-1:0];
    end else if (code < REG_PC) begin
      word_file[3'(code - REG_WORD0)] = value;
    end else if (code == REG_PC) begin
      pc_reg = value;
    end
  endfunction

  function automatic result_t execute_instr(input instr_t ins);
    result_t res;
    res.pc_modified = 1'b0;
    case (ins.func)
      FUNC_SET: begin
        write_reg(ins.dest_reg, ins.immediate);
        if (ins.dest_reg == REG_PC) res.pc_modified = 1'b1;
      end
      FUNC_SUM: begin
        write_reg(ins.dest_reg, read_reg(ins.dest_reg) + read_reg(ins.src_reg));
      end
      FUNC_SUB: begin
        write_reg(ins.dest_reg, read_reg(ins.dest_reg) - read_reg(ins.src_reg));
      end
      default: begin
        // A jump is taken only on a nonzero register; unused codes read zero.
        if (read_reg(ins.dest_reg) != '0) pc_reg = ins.immediate;
        else pc_reg = pc_reg + 1'b1;
        res.pc_modified = 1'b1;
      end
    endcase
    res.pc_value   = pc_reg;
    res.dest_value = read_reg(ins.dest_reg);
    return res;
  endfunction

  always @(posedge clk) begin
    instr_t  ins;
    result_t got;
    result_t want;
    if (!rst_n) begin
      foreach (byte_file[i]) byte_file[i] = '0;
      foreach (word_file[i]) word_file[i] = '0;
      pc_reg = '0;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.pc_value    = out_ch.pc_value;
        got.pc_modified = out_ch.pc_modified;
        got.dest_value  = out_ch.dest_value;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: pc %h mod %b dest %h",
                                    got.pc_value, got.pc_modified, got.dest_value));
        end else begin
          want = expected_results.pop_front();
          if (got.pc_value !== want.pc_value) begin
            report_mismatch($sformatf("pc_value got %h want %h",
                                      got.pc_value, want.pc_value));
          end
          if (got.pc_modified !== want.pc_modified) begin
            report_mismatch($sformatf("pc_modified got %b want %b",
                                      got.pc_modified, want.pc_modified));
          end
          if (got.dest_value !== want.dest_value) begin
            report_mismatch($sformatf("dest_value got %h want %h",
                                      got.dest_value, want.dest_value));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        ins.func      = in_ch.func;
        ins.dest_reg  = in_ch.dest_reg;
        ins.src_reg   = in_ch.src_reg;
        ins.immediate = in_ch.immediate;
        expected_results.push_back(execute_instr(ins));
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== tb/sv/tb_register_file_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_register_file_execute_unit - testbench top for the execute unit
// Drives a directed instruction sequence and then random programs through the
// instruction channel under three idle patterns, while the checker predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_register_file_execute_unit;
  import rfeu_pkg::*;

  localparam logic [REG_W-1:0] REG_BYTE0     = 4'd0;
  localparam logic [REG_W-1:0] REG_BYTE1     = 4'd1;
  localparam logic [REG_W-1:0] REG_BYTE3     = 4'd3;
  localparam logic [REG_W-1:0] REG_WORD1     = 4'd5;
  localparam logic [REG_W-1:0] REG_WORD3     = 4'd7;
  localparam logic [REG_W-1:0] REG_UNUSED_LO = 4'd11;
  localparam logic [REG_W-1:0] REG_UNUSED_HI = 4'd15;

  localparam int RANDOM_PER_PHASE = 142;

  logic        clk = 1'b0;
  logic        rst_n;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int unsigned mismatch_count;
  int unsigned outstanding;

  rfeu_in_if  in_if ();
  rfeu_out_if out_if ();

  register_file_execute_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  register_file_execute_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_if),
    .out_ch         (out_if),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  task automatic send_instr(input logic [FUNC_W-1:0] func,
                            input logic [REG_W-1:0]  dest,
                            input logic [REG_W-1:0]  src,
                            input logic [WORD_W-1:0] imm);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= func;
    in_if.dest_reg  <= dest;
    in_if.src_reg   <= src;
    in_if.immediate <= imm;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] pick_reg();
    // Unused codes show up now and then; most traffic hits real registers.
    if ($urandom_range(9) == 0) return REG_W'($urandom_range(15, 11));
    return REG_W'($urandom_range(10));
  endfunction

  function automatic logic [WORD_W-1:0] pick_immediate();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return WORD_W'($urandom_range(255));
      2:       return '0;
      default: return 32'hFFFF_FFFF ^ WORD_W'($urandom_range(15));
    endcase
  endfunction

  task automatic run_random_program(input int count);
    repeat (count) begin
      send_instr(FUNC_W'($urandom_range(3)), pick_reg(), pick_reg(), pick_immediate());
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    tx_idle_pct     <= 20;
    rx_idle_pct     <= 62;
    in_if.valid     <= 1'b0;
    in_if.func      <= FUNC_SET;
    in_if.dest_reg  <= REG_BYTE0;
    in_if.src_reg   <= REG_BYTE0;
    in_if.immediate <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: width truncation, zero extension, PC handling, unused codes.
    send_instr(FUNC_SET, REG_BYTE0, REG_BYTE0, 32'hFFFF_FFFF);
    send_instr(FUNC_SET, REG_BYTE3, REG_BYTE0, 32'h0000_01A5);
    send_instr(FUNC_SET, REG_WORD0, REG_BYTE0, 32'hFFFF_FFFF);
    send_instr(FUNC_SET, REG_WORD3, REG_BYTE0, 32'h8000_0001);
    send_instr(FUNC_SET, REG_SI, REG_BYTE0, 32'hFFFF_0000);
    send_instr(FUNC_SET, REG_DI, REG_BYTE0, 32'h0000_FFFF);
    send_instr(FUNC_SET, REG_PC, REG_BYTE0, 32'hFFFF_FFFF);
    send_instr(FUNC_JNZ, REG_BYTE1, REG_BYTE0, 32'h1234_5678);
    send_instr(FUNC_SUM, REG_BYTE0, REG_WORD0, 32'h0);
    send_instr(FUNC_SUB, REG_BYTE1, REG_BYTE0, 32'h0);
    send_instr(FUNC_SUM, REG_WORD1, REG_BYTE3, 32'h0);
    send_instr(FUNC_SUM, REG_PC, REG_WORD0, 32'h0);
    send_instr(FUNC_SUM, REG_WORD0, REG_PC, 32'h0);
    send_instr(FUNC_SUB, REG_PC, REG_PC, 32'h0);
    send_instr(FUNC_SUB, REG_SI, REG_DI, 32'h0);
    send_instr(FUNC_SUB, REG_DI, REG_SI, 32'h0);
    send_instr(FUNC_SET, REG_UNUSED_LO, REG_BYTE0, 32'hDEAD_BEEF);
    send_instr(FUNC_SET, REG_UNUSED_HI, REG_UNUSED_HI, 32'hFFFF_FFFF);
    send_instr(FUNC_JNZ, REG_UNUSED_LO, REG_BYTE0, 32'hFFFF_FFFF);
    send_instr(FUNC_SUM, REG_UNUSED_HI, REG_WORD0, 32'h0);
    send_instr(FUNC_SUM, REG_WORD1, REG_UNUSED_HI, 32'h0);
    send_instr(FUNC_JNZ, REG_WORD0, REG_BYTE0, 32'hFFFF_FFFF);
    send_instr(FUNC_JNZ, REG_BYTE0, REG_BYTE0, 32'h0);
    send_instr(FUNC_JNZ, REG_PC, REG_BYTE0, 32'hA5A5_5A5A);

    run_random_program(RANDOM_PER_PHASE);

    tx_idle_pct <= 62;
    rx_idle_pct <= 20;
    run_random_program(RANDOM_PER_PHASE);

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    run_random_program(RANDOM_PER_PHASE);

    in_if.valid <= 1'b0;
    // Let the checker count the last transaction before waiting for the drain.
    @(posedge clk);
    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rfeu_pkg.sv
rtl/core/rfeu_channels.sv
rtl/core/rfeu_regfile.sv
rtl/core/rfeu_exec.sv
rtl/core/register_file_execute_unit.sv
tb/sv/register_file_execute_checker.sv
tb/sv/tb_register_file_execute_unit.sv
